/* rtl/tps_pkg.sv */
`timescale 1ns / 1ps
package tps_pkg;
   localparam int FREQ_W = 48;
   localparam int MCK_W = 32;
   localparam int CMP_W = 32;
   localparam int SEL_W = 2;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam logic [MCK_W-1:0] MCK_RESET = 32'd84000000;

   typedef struct packed {
      logic [SEL_W-1:0] clock_select;
      logic [CMP_W-1:0] compare_value;
      logic             overflow;
   } rsp_type;
endpackage

/* rtl/tps_div.sv */
`timescale 1ns / 1ps
module tps_div
   import tps_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int NB = MCK_W + 2 * FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NB-1:0]     in_num,
   input  logic [FREQ_W-1:0] in_den,
   output logic              out_valid,
   output logic [NB-1:0]     out_quo
);
   localparam int RW = FREQ_W + 1;

   logic              valid_ff [0:NB];
   logic [RW-1:0]     rem_ff   [0:NB];
   logic [NB-1:0]     num_ff   [0:NB];
   logic [NB-1:0]     quo_ff   [0:NB];
   logic [FREQ_W-1:0] den_ff   [0:NB];

   // load the entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0] <= '0;
      num_ff[0] <= in_num;
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
   end

   // one restoring quotient bit per stage
   for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [RW-1:0] part_in;
      logic          take_in;
      always_comb begin
         part_in = {rem_ff[k][RW-2:0], num_ff[k][NB-1]};
         take_in = part_in >= {1'b0, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1] <= take_in ? (part_in - {1'b0, den_ff[k]}) : part_in;
         num_ff[k+1] <= {num_ff[k][NB-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][NB-2:0], take_in};
         den_ff[k+1] <= den_ff[k];
      end
   end

   assign out_valid = valid_ff[NB];
   assign out_quo   = quo_ff[NB];
endmodule

/* rtl/tps_select.sv */
`timescale 1ns / 1ps
module tps_select
   import tps_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
   localparam int NB = MCK_W + 2 * FRACTION_BITS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NB-1:0] in_quo,
   output logic          out_valid,
   output rsp_type       out_rsp
);
   localparam int FB = FRACTION_BITS;
   localparam logic [FB:0] ONE_Q = {1'b1, {FB{1'b0}}};
   localparam logic [NB:0] HALF_Q = (NB + 1)'(1) << (FB - 1);

   logic             valid_a_ff;
   logic [SEL_W-1:0] sel_a_ff;
   logic [NB-1:0]    quo_a_ff;
   logic [SEL_W-1:0] sel_in;
   logic             valid_b_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic [NB-1:0]    ticks;
   logic [NB:0]      rounded;
   logic [NB-FB:0]   whole;

   // pick the candidate nearest an integer, divisor 128 first, strict improvement
   always_comb begin
      logic [FB-1:0] frac;
      logic [FB:0]   err;
      logic [FB:0]   best;
      best   = ONE_Q;
      sel_in = SEL_W'(3);
      for (int i = 3; i >= 0; i--) begin
         frac = FB'(in_quo >> (2 * i + 1));
         err  = ({1'b0, frac} <= ONE_Q - {1'b0, frac}) ? {1'b0, frac}
                                                       : ONE_Q - {1'b0, frac};
         if (err < best) begin
            best   = err;
            sel_in = SEL_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      sel_a_ff <= sel_in;
      quo_a_ff <= in_quo;
   end

   // round half up and saturate
   always_comb begin
      ticks   = quo_a_ff >> ({1'b0, sel_a_ff, 1'b0} + 4'd1);
      rounded = {1'b0, ticks} + HALF_Q;
      whole   = rounded[NB:FB];
      rsp_in.clock_select = sel_a_ff;
      if (whole[NB-FB:CMP_W] != '0) begin
         rsp_in.compare_value = '1;
         rsp_in.overflow      = 1'b1;
      end else begin
         rsp_in.compare_value = whole[CMP_W-1:0];
         rsp_in.overflow      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_b_ff;
   assign out_rsp   = rsp_ff;

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_rsp.overflow |-> out_rsp.compare_value == '1)
      else $error("overflow without saturated compare value");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff |=> valid_b_ff)
      else $error("item lost between select and output stage");
   a_sel_keep: assert property (@(posedge clock) disable iff (reset)
      valid_a_ff |=> rsp_ff.clock_select == $past(sel_a_ff))
      else $error("clock select changed in rounding stage");
endmodule

/* rtl/timer_prescaler_selector_core.sv */
`timescale 1ns / 1ps
// Timer prescaler and compare value selector.
// Request: pulse req_start with req_frequency_q16 (unsigned Q32.16 Hz, zero
// means 1 Hz). busy is always low, so an item is taken in every cycle that
// req_start is high. Result: rsp_valid is high for one cycle with
// rsp_clock_select (0..3 = div 2, 8, 32, 128), rsp_compare_value and
// rsp_overflow. The receiver cannot stall; results leave in request order.
// The pipeline holds, in order:
// one entry stage, one restoring quotient bit per stage for the single
// division master_clock * 2^(2F) / f, one candidate select stage and one
// rounding stage. Throughput is one item per cycle.
// csr_write_enable/csr_write_data set master_clock_hz; write it only while
// no item is in flight. Reset clears the pipeline valid bits and sets
// master_clock_hz to 84000000.
module timer_prescaler_selector_core
   import tps_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              busy,
   input  logic [FREQ_W-1:0] req_frequency_q16,
   output logic              rsp_valid,
   output logic [SEL_W-1:0]  rsp_clock_select,
   output logic [CMP_W-1:0]  rsp_compare_value,
   output logic              rsp_overflow,
   input  logic              csr_write_enable,
   input  logic [MCK_W-1:0]  csr_write_data
);
   localparam int NB = MCK_W + 2 * FRACTION_BITS;
   localparam int LAT = NB + 3;

   logic [MCK_W-1:0]  mck_ff;
   logic [MCK_W-1:0]  mck_in;
   logic [FREQ_W-1:0] den;
   logic [NB-1:0]     num;
   logic              div_valid;
   logic [NB-1:0]     div_quo;
   rsp_type           rsp;

   // hold the master clock register
   always_comb begin
      mck_in = csr_write_enable ? csr_write_data : mck_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mck_ff <= MCK_RESET;
      end else begin
         mck_ff <= mck_in;
      end
   end

   // form numerator and divisor; zero frequency stands for 1 Hz
   always_comb begin
      den = (req_frequency_q16 == '0) ? (FREQ_W'(1) << FRACTION_BITS) : req_frequency_q16;
      num = {mck_ff, {(2 * FRACTION_BITS){1'b0}}};
   end

   assign busy = 1'b0;

   tps_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_start && !busy),
      .in_num    (num),
      .in_den    (den),
      .out_valid (div_valid),
      .out_quo   (div_quo)
   );

   tps_select #(.FRACTION_BITS(FRACTION_BITS)) u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_quo    (div_quo),
      .out_valid (rsp_valid),
      .out_rsp   (rsp)
   );

   assign rsp_clock_select  = rsp.clock_select;
   assign rsp_compare_value = rsp.compare_value;
   assign rsp_overflow      = rsp.overflow;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, LAT))
      else $error("result without a matching item");
   a_mck_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> mck_ff == $past(csr_write_data))
      else $error("master clock write lost");
   a_mck_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_enable |=> $stable(mck_ff))
      else $error("master clock changed without a write");
endmodule
